// ===== rtl/core/nds_pkg.sv =====
// Shared constants, types and helper function of the NRZI preamble sync decoder.
`default_nettype none

package nds_pkg;

  localparam int LENGTH_WIDTH = 32;
  localparam int INDEX_WIDTH  = 48;
  localparam int MAX_PREAMBLE = 64;

  localparam int SUM_WIDTH  = LENGTH_WIDTH + $clog2(MAX_PREAMBLE);
  localparam int SEEN_WIDTH = $clog2(MAX_PREAMBLE + 1);

  localparam int K_WIDTH    = 3;
  localparam int DATA_WIDTH = 32;
  localparam int PADDR_W    = 3;

  localparam logic [K_WIDTH-1:0] K_MIN   = 3'd2;
  localparam logic [K_WIDTH-1:0] K_MAX   = 3'd6;
  localparam logic [K_WIDTH-1:0] K_RESET = 3'd4;

  localparam logic REG_PREAMBLE_LOG2 = 1'b0;

  localparam logic KIND_PREAMBLE = 1'b0;
  localparam logic KIND_BIT      = 1'b1;

  typedef struct packed {
    logic [K_WIDTH-1:0] preamble_log2;
  } nds_cfg_t;

  function automatic logic [K_WIDTH-1:0] eff_log2(input logic [K_WIDTH-1:0] raw);
    logic [K_WIDTH-1:0] k;
    k = raw;
    if (k < K_MIN) k = K_MIN;
    if (k > K_MAX) k = K_MAX;
    for (int i = 0; i < 6; i++) begin
      if ((k > 0) && ((32'd1 << k) > 32'(MAX_PREAMBLE))) k = k - 1'b1;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nds_if.sv =====
// Stream interfaces for the sample input and the result output channels.
`default_nettype none

interface nds_in_if;
  logic valid;
  logic ready;
  logic data_sample;

  modport source (output valid, output data_sample, input ready);
  modport sink   (input valid, input data_sample, output ready);
endinterface

interface nds_out_if import nds_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    result_kind;
  logic                    bit_value;
  logic [INDEX_WIDTH-1:0]  span_start;
  logic [INDEX_WIDTH-1:0]  span_end;
  logic [LENGTH_WIDTH-1:0] symbol_length;

  modport source (output valid, output result_kind, output bit_value, output span_start,
                  output span_end, output symbol_length, input ready);
  modport sink   (input valid, input result_kind, input bit_value, input span_start,
                  input span_end, input symbol_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nds_cfg_regs.sv =====
// APB register file holding the preamble length setting.
`default_nettype none

module nds_cfg_regs import nds_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output logic      [DATA_WIDTH-1:0] prdata,
  output logic                       pready,
  output nds_cfg_t                   cfg
);

  logic [K_WIDTH-1:0] preamble_log2;
  logic               sel_k;

  assign pready = 1'b1;
  assign sel_k  = (paddr[PADDR_W-1:2] == REG_PREAMBLE_LOG2);

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_log2 <= K_RESET;
    end else if (psel && penable && pwrite && pready && sel_k) begin
      preamble_log2 <= pwdata[K_WIDTH-1:0];
    end
  end

  assign prdata = sel_k ? DATA_WIDTH'(preamble_log2) : '0;
  assign cfg.preamble_log2 = preamble_log2;

endmodule

`default_nettype wire

// ===== rtl/core/nds_decoder_core.sv =====
// Preamble timing, symbol length recovery and bit window decoding with result register.
`default_nettype none

module nds_decoder_core import nds_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire nds_cfg_t cfg,
  nds_in_if.sink        sample_ch,
  nds_out_if.source     result_ch
);

  typedef enum logic [2:0] {
    PH_PRIME,
    PH_HUNT,
    PH_SYNC,
    PH_SKIP,
    PH_WINDOW,
    PH_TAIL
  } phase_t;

  phase_t                  phase, phase_next;
  logic                    previous_level, previous_level_next;
  logic [INDEX_WIDTH-1:0]  sample_index, sample_index_next;
  logic [LENGTH_WIDTH-1:0] period_counter, period_counter_next;
  logic [SUM_WIDTH-1:0]    period_sum, period_sum_next;
  logic [SEEN_WIDTH-1:0]   periods_seen, periods_seen_next;
  logic [LENGTH_WIDTH-1:0] recovered_length, recovered_length_next;
  logic [LENGTH_WIDTH-1:0] window_counter, window_counter_next;
  logic [INDEX_WIDTH-1:0]  window_start, window_start_next;
  logic [INDEX_WIDTH-1:0]  preamble_begin, preamble_begin_next;

  logic                    acc, lvl, rise, edge_seen;
  logic [K_WIDTH-1:0]      k_eff;
  logic [SEEN_WIDTH-1:0]   np;
  logic [LENGTH_WIDTH-1:0] cnt_sat, len_calc, half_calc, rem, win_inc, win_dec;
  logic                    seen_room;
  logic [SUM_WIDTH-1:0]    sum_upd;
  logic [SEEN_WIDTH-1:0]   seen_upd;
  logic [SUM_WIDTH:0]      round_sum;
  logic [K_WIDTH:0]        shift_amt;

  logic                    emit, res_kind, res_bit;
  logic [INDEX_WIDTH-1:0]  res_start;
  logic [LENGTH_WIDTH-1:0] res_len;

  assign sample_ch.ready = !result_ch.valid || result_ch.ready;
  assign acc       = sample_ch.valid && sample_ch.ready;
  assign lvl       = sample_ch.data_sample;
  assign rise      = !previous_level && lvl;
  assign edge_seen = previous_level != lvl;

  assign k_eff     = eff_log2(cfg.preamble_log2);
  assign np        = SEEN_WIDTH'(1) << k_eff;
  assign cnt_sat   = (period_counter == '1) ? period_counter : period_counter + 1'b1;
  assign seen_room = periods_seen < SEEN_WIDTH'(MAX_PREAMBLE);
  assign sum_upd   = seen_room ? period_sum + SUM_WIDTH'(cnt_sat) : period_sum;
  assign seen_upd  = seen_room ? periods_seen + 1'b1 : periods_seen;
  assign round_sum = {1'b0, sum_upd} + (SUM_WIDTH + 1)'(np);
  assign shift_amt = {1'b0, k_eff} + 1'b1;
  assign len_calc  = LENGTH_WIDTH'(round_sum >> shift_amt);
  assign half_calc = len_calc >> 1;
  assign rem       = recovered_length - (recovered_length >> 1);
  assign win_inc   = window_counter + 1'b1;
  assign win_dec   = (window_counter != '0) ? window_counter - 1'b1 : window_counter;

  always_comb begin
    phase_next            = phase;
    previous_level_next   = previous_level;
    sample_index_next     = sample_index;
    period_counter_next   = period_counter;
    period_sum_next       = period_sum;
    periods_seen_next     = periods_seen;
    recovered_length_next = recovered_length;
    window_counter_next   = window_counter;
    window_start_next     = window_start;
    preamble_begin_next   = preamble_begin;
    emit      = 1'b0;
    res_kind  = KIND_BIT;
    res_bit   = 1'b0;
    res_start = window_start;
    res_len   = recovered_length;

    if (acc) begin
      sample_index_next   = sample_index + 1'b1;
      previous_level_next = lvl;
      unique case (phase)
        PH_PRIME: begin
          phase_next = PH_HUNT;
        end
        PH_HUNT: begin
          if (rise) begin
            preamble_begin_next = sample_index;
            period_counter_next = '0;
            period_sum_next     = '0;
            periods_seen_next   = '0;
            phase_next          = PH_SYNC;
          end
        end
        PH_SYNC: begin
          period_counter_next = cnt_sat;
          if (rise) begin
            period_sum_next     = sum_upd;
            periods_seen_next   = seen_upd;
            period_counter_next = '0;
            if (seen_upd >= np) begin
              recovered_length_next = len_calc;
              emit      = 1'b1;
              res_kind  = KIND_PREAMBLE;
              res_start = preamble_begin;
              res_len   = len_calc;
              if (half_calc == '0) begin
                window_start_next   = sample_index;
                window_counter_next = '0;
                phase_next          = PH_WINDOW;
              end else begin
                window_counter_next = half_calc;
                phase_next          = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          window_counter_next = win_dec;
          if (win_dec == '0) begin
            window_start_next = sample_index;
            phase_next        = PH_WINDOW;
          end
        end
        PH_WINDOW: begin
          window_counter_next = win_inc;
          if (edge_seen) begin
            if (rem == '0) begin
              emit                = 1'b1;
              res_bit             = 1'b1;
              window_start_next   = sample_index;
              window_counter_next = '0;
            end else begin
              window_counter_next = rem;
              phase_next          = PH_TAIL;
            end
          end else if (win_inc >= recovered_length) begin
            emit                = 1'b1;
            window_start_next   = sample_index;
            window_counter_next = '0;
          end
        end
        PH_TAIL: begin
          window_counter_next = win_dec;
          if (win_dec == '0) begin
            emit              = 1'b1;
            res_bit           = 1'b1;
            window_start_next = sample_index;
            phase_next        = PH_WINDOW;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_PRIME;
      previous_level   <= 1'b0;
      sample_index     <= '0;
      period_counter   <= '0;
      period_sum       <= '0;
      periods_seen     <= '0;
      recovered_length <= '0;
      window_counter   <= '0;
      window_start     <= '0;
      preamble_begin   <= '0;
      result_ch.valid  <= 1'b0;
    end else begin
      phase            <= phase_next;
      previous_level   <= previous_level_next;
      sample_index     <= sample_index_next;
      period_counter   <= period_counter_next;
      period_sum       <= period_sum_next;
      periods_seen     <= periods_seen_next;
      recovered_length <= recovered_length_next;
      window_counter   <= window_counter_next;
      window_start     <= window_start_next;
      preamble_begin   <= preamble_begin_next;
      if (result_ch.valid && result_ch.ready) begin
        result_ch.valid <= 1'b0;
      end
      if (emit) begin
        result_ch.valid <= 1'b1;
      end
    end
    if (emit) begin
      result_ch.result_kind   <= res_kind;
      result_ch.bit_value     <= res_bit;
      result_ch.span_start    <= res_start;
      result_ch.span_end      <= sample_index;
      result_ch.symbol_length <= res_len;
    end
  end

`ifndef SYNTHESIS
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (window_counter != '0))
    else $error("Skip phase with an empty counter.");

  a_tail_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TAIL) |-> (window_counter != '0))
    else $error("Tail phase with an empty counter.");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WINDOW) |-> ((window_counter < recovered_length) || (window_counter == '0)))
    else $error("Window counter ran past the symbol length.");

  a_seen_cap: assert property (@(posedge clk) disable iff (rst)
    periods_seen <= SEEN_WIDTH'(MAX_PREAMBLE))
    else $error("Preamble period count passed its cap.");

  a_span_end: assert property (@(posedge clk) disable iff (rst)
    emit |=> (result_ch.valid && (result_ch.span_end == $past(sample_index))))
    else $error("Result transfer does not end at the sample that caused it.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/nrzi_decoder_preamble_sync.sv =====
// Top level of the NRZI decoder with preamble clock recovery.
// The block takes one data-line sample per clock cycle, back to back, as long as the result
// register is empty or being drained in the same cycle. Each sample is processed in the
// cycle it is accepted, and any result it causes (a preamble report or a decoded bit) is
// available from the result register in the next cycle, so while results drain the rate is
// one sample per cycle, set by the single update pass over the period, window and index
// counters. A stalled result register holds back new samples until its transfer completes.
// The preamble length is 2^k periods, with k (clamped to 2..6 in use) written at byte address
// 0 of the APB port while the block is idle.
`default_nettype none

module nrzi_decoder_preamble_sync import nds_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  nds_in_if.sink                     sample_ch,
  nds_out_if.source                  result_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output logic      [DATA_WIDTH-1:0] prdata,
  output logic                       pready
);

  nds_cfg_t cfg;

  nds_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nds_decoder_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

endmodule

`default_nettype wire
